// ----- rtl/core/zero_padded_2d_convolution_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ZERO_PADDED_2D_CONVOLUTION_MACROS_SVH
`define ZERO_PADDED_2D_CONVOLUTION_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ZPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ZPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/zpc_pkg.sv -----
package zpc_pkg;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 1024;
    localparam int DEF_MAX_KERNEL     = 9;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int IDX_W      = 7;
    localparam int REQ_W      = 2;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int KSIZE_W    = 4;
    localparam int PIX_MAX    = 255;

    localparam logic [REQ_W-1:0] REQ_COEF  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMG_W = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMG_H = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KER_W = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KER_H = 2'd3;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic coef_we;
        logic step;
        logic emit;
        logic last;
    } zpc_tag_t;

endpackage

// ----- rtl/core/zero_padded_2d_convolution.sv -----
// Zero padded 2-D correlation of an 8-bit pixel stream.
// Input stream s_*: tuser carries the request kind (coefficient write, pixel,
// flush step); tdata carries coefficient index, Q3.12 coefficient and pixel.
// Pixels arrive in raster order; after the last pixel, send one flush step per
// output still pending ((kh-1-kh/2)*width + (kw-1-kw/2) of them).
// Output stream m_*: one filtered pixel per transfer, tlast on the final
// pixel of the image.
// Config port cfg_*: image width, image height, kernel width, kernel height;
// any write restarts the frame. Write only while the block is idle.
// Throughput: one item per clock while the receiver does not stall. The path
// from the transfer of the item that completes its window to its output is the
// line buffer read, the read-modify-write together with the window shift, the
// multiply stage, two adder tree stages and the clip into the output register.
// Reset clears the frame position and the pipeline; the line buffer needs no
// clearing pass, as rows outside the image are masked. Coefficients are
// undefined until written.
// When the receiver stalls, the whole pipeline holds and s_tready drops
// together with it; the held result stays in the output register.
module zero_padded_2d_convolution import zpc_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL     = DEF_MAX_KERNEL,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [6:0] coef_index, [22:7] coef_value, [30:23] pixel_value, [31] zero
    input  logic [31:0]            s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]       s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] out_pixel
    output logic [PIX_W-1:0]       m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic adv, accept;
    logic [ADDR_W-1:0] rd_addr, s1_col;
    zpc_tag_t s1_tag;
    logic [PIX_W-1:0] s1_pix;
    logic [IDX_W-1:0] s1_coef_idx;
    logic signed [COEF_W-1:0] s1_coef_val;
    logic [MAX_KERNEL-1:0] s1_rowmask, s1_colmask;
    logic [KSIZE_W-1:0] ker_w, ker_h;
    logic [MAX_KERNEL-1:0][PIX_W-1:0] col;

    // Advance everything unless a result waits on a stalled receiver
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    zpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .accept      (accept),
        .req         (s_tuser),
        .coef_idx    (s_tdata[6:0]),
        .coef_val    ($signed(s_tdata[22:7])),
        .pix         (s_tdata[30:23]),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rd_addr     (rd_addr),
        .s1_tag      (s1_tag),
        .s1_col      (s1_col),
        .s1_pix      (s1_pix),
        .s1_coef_idx (s1_coef_idx),
        .s1_coef_val (s1_coef_val),
        .s1_rowmask  (s1_rowmask),
        .s1_colmask  (s1_colmask),
        .ker_w       (ker_w),
        .ker_h       (ker_h)
    );

    zpc_linebuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_linebuf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (adv && s1_tag.step),
        .wr_addr (s1_col),
        .wr_pix  (s1_pix),
        .ker_h   (ker_h),
        .col     (col)
    );

    zpc_mac #(
        .MAX_KERNEL     (MAX_KERNEL),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .s1_tag      (s1_tag),
        .col         (col),
        .s1_rowmask  (s1_rowmask),
        .s1_colmask  (s1_colmask),
        .s1_coef_idx (s1_coef_idx),
        .s1_coef_val (s1_coef_val),
        .ker_w       (ker_w),
        .out_valid   (m_tvalid),
        .out_pixel   (m_tdata),
        .out_last    (m_tlast)
    );

endmodule

// ----- rtl/core/zpc_front.sv -----
module zpc_front import zpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL,
    localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         accept,
    input  logic [REQ_W-1:0]             req,
    input  logic [IDX_W-1:0]             coef_idx,
    input  logic signed [COEF_W-1:0]     coef_val,
    input  logic [PIX_W-1:0]             pix,
    input  logic                         cfg_we,
    input  logic [CFG_ADDR_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    output logic [ADDR_W-1:0]            rd_addr,
    output zpc_tag_t                     s1_tag,
    output logic [ADDR_W-1:0]            s1_col,
    output logic [PIX_W-1:0]             s1_pix,
    output logic [IDX_W-1:0]             s1_coef_idx,
    output logic signed [COEF_W-1:0]     s1_coef_val,
    output logic [MAX_KERNEL-1:0]        s1_rowmask,
    output logic [MAX_KERNEL-1:0]        s1_colmask,
    output logic [KSIZE_W-1:0]           ker_w,
    output logic [KSIZE_W-1:0]           ker_h
);

    localparam int WDT_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int AW     = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_KERNEL + 1) + 1;
    localparam int LEAD_W = $clog2(MAX_KERNEL * MAX_WIDTH + 1);
    localparam int W_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RST  = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
    localparam int K_RST  = (MAX_KERNEL < 3) ? MAX_KERNEL : 3;

    logic [WDT_W-1:0]   img_w_reg, img_w_next;
    logic [HGT_W-1:0]   img_h_reg, img_h_next;
    logic [KSIZE_W-1:0] ker_w_reg, ker_w_next;
    logic [KSIZE_W-1:0] ker_h_reg, ker_h_next;
    logic [ADDR_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ADDR_W-1:0]  ocol_reg, ocol_next;
    logic [OROW_W-1:0]  orow_reg, orow_next;
    logic [LEAD_W-1:0]  lead_reg, lead_next;

    zpc_tag_t           s1_tag_reg, tag;
    logic [ADDR_W-1:0]  s1_col_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic signed [COEF_W-1:0] s1_val_reg;
    logic [MAX_KERNEL-1:0] s1_rowmask_reg, s1_colmask_reg, rowmask, colmask;

    logic [AW-1:0] w_a, h_a, kw_a, kh_a, pad_w, pad_h, lat_c, lat_r;
    logic [AW-1:0] row_a, ocol_a, orow_a;
    logic [LEAD_W-1:0] lat_total;
    logic          in_frame, step, emit, last;
    logic [KSIZE_W-1:0] k_raw, k_clamped;

    always_comb begin
        w_a    = AW'(img_w_reg);
        h_a    = AW'(img_h_reg);
        kw_a   = AW'(ker_w_reg);
        kh_a   = AW'(ker_h_reg);
        pad_w  = AW'(ker_w_reg >> 1);
        pad_h  = AW'(ker_h_reg >> 1);
        lat_c  = kw_a - AW'(1) - pad_w;
        lat_r  = kh_a - AW'(1) - pad_h;
        row_a  = AW'(row_reg);
        ocol_a = AW'(ocol_reg);
        orow_a = AW'(orow_reg);
        // Steps taken before the first output of the frame
        lat_total = LEAD_W'(lat_r) * LEAD_W'(w_a) + LEAD_W'(lat_c);

        in_frame = row_a < h_a;
        step     = (req == REQ_PIXEL) || ((req == REQ_FLUSH) && !in_frame);
        emit     = step && (lead_reg >= lat_total);
        last     = emit && (orow_a == h_a - AW'(1)) && (ocol_a == w_a - AW'(1));

        // Which kernel rows and columns land inside the image for this output
        for (int k = 0; k < MAX_KERNEL; k++) begin
            colmask[k] = (AW'(k) < kw_a) && (ocol_a + AW'(k) >= pad_w)
                         && (ocol_a + AW'(k) < w_a + pad_w);
            rowmask[k] = (AW'(k) < kh_a) && (orow_a + AW'(k) >= pad_h)
                         && (orow_a + AW'(k) < h_a + pad_h);
        end

        tag.coef_we = (req == REQ_COEF) && (int'(coef_idx) < MAX_KERNEL * MAX_KERNEL);
        tag.step    = step;
        tag.emit    = emit;
        tag.last    = last;
    end

    always_comb begin
        k_raw = cfg_data[KSIZE_W-1:0];
        if (k_raw == '0) begin
            k_clamped = KSIZE_W'(1);
        end else if (int'(k_raw) > MAX_KERNEL) begin
            k_clamped = KSIZE_W'(MAX_KERNEL);
        end else begin
            k_clamped = k_raw;
        end
    end

    always_comb begin
        img_w_next = img_w_reg;
        img_h_next = img_h_reg;
        ker_w_next = ker_w_reg;
        ker_h_next = ker_h_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        lead_next  = lead_reg;
        if (cfg_we) begin
            // Any register write restarts the frame
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
            lead_next = '0;
            unique case (cfg_index)
                CFG_IMG_W: begin
                    if (cfg_data == '0) begin
                        img_w_next = WDT_W'(1);
                    end else if (int'(cfg_data) > MAX_WIDTH) begin
                        img_w_next = WDT_W'(MAX_WIDTH);
                    end else begin
                        img_w_next = WDT_W'(cfg_data);
                    end
                end
                CFG_IMG_H: begin
                    if (cfg_data == '0) begin
                        img_h_next = HGT_W'(1);
                    end else if (int'(cfg_data) > MAX_HEIGHT) begin
                        img_h_next = HGT_W'(MAX_HEIGHT);
                    end else begin
                        img_h_next = HGT_W'(cfg_data);
                    end
                end
                CFG_KER_W: ker_w_next = k_clamped;
                CFG_KER_H: ker_h_next = k_clamped;
                default: ;
            endcase
        end else if (accept && step) begin
            if (last) begin
                col_next  = '0;
                row_next  = '0;
                ocol_next = '0;
                orow_next = '0;
                lead_next = '0;
            end else begin
                if (lead_reg < lat_total) begin
                    lead_next = lead_reg + LEAD_W'(1);
                end
                if (AW'(col_reg) + AW'(1) >= w_a) begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + ADDR_W'(1);
                end
                if (emit) begin
                    if (ocol_a + AW'(1) >= w_a) begin
                        ocol_next = '0;
                        orow_next = orow_reg + OROW_W'(1);
                    end else begin
                        ocol_next = ocol_reg + ADDR_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg  <= WDT_W'(W_RST);
            img_h_reg  <= HGT_W'(H_RST);
            ker_w_reg  <= KSIZE_W'(K_RST);
            ker_h_reg  <= KSIZE_W'(K_RST);
            col_reg    <= '0;
            row_reg    <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            lead_reg   <= '0;
            s1_tag_reg <= '0;
        end else begin
            img_w_reg <= img_w_next;
            img_h_reg <= img_h_next;
            ker_w_reg <= ker_w_next;
            ker_h_reg <= ker_h_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ocol_reg  <= ocol_next;
            orow_reg  <= orow_next;
            lead_reg  <= lead_next;
            if (adv) begin
                s1_tag_reg <= accept ? tag : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg     <= col_reg;
            s1_pix_reg     <= pix;
            s1_idx_reg     <= coef_idx;
            s1_val_reg     <= coef_val;
            s1_rowmask_reg <= rowmask;
            s1_colmask_reg <= colmask;
        end
    end

    assign rd_addr     = col_reg;
    assign s1_tag      = s1_tag_reg;
    assign s1_col      = s1_col_reg;
    assign s1_pix      = s1_pix_reg;
    assign s1_coef_idx = s1_idx_reg;
    assign s1_coef_val = s1_val_reg;
    assign s1_rowmask  = s1_rowmask_reg;
    assign s1_colmask  = s1_colmask_reg;
    assign ker_w       = ker_w_reg;
    assign ker_h       = ker_h_reg;

endmodule

// ----- rtl/core/zpc_linebuf.sv -----
module zpc_linebuf import zpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL,
    localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic [PIX_W-1:0]                  wr_pix,
    input  logic [KSIZE_W-1:0]                ker_h,
    output logic [MAX_KERNEL-1:0][PIX_W-1:0]  col
);

    // Each word holds one image column of the previous rows, newest in slot 0
    localparam int LB_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

    typedef logic [LB_ROWS-1:0][PIX_W-1:0] lb_word_t;

    lb_word_t line_mem_reg [MAX_WIDTH];
    lb_word_t rd_data_reg;
    lb_word_t byp_data_reg;
    logic     byp_reg;
    lb_word_t old_word;
    lb_word_t wr_word;
    logic [MAX_KERNEL-1:0][PIX_W-1:0] stack;

    always_comb begin
        // Forward the word written in the same cycle as this read
        old_word = byp_reg ? byp_data_reg : rd_data_reg;
        wr_word  = old_word;
        wr_word[0] = wr_pix;
        for (int i = 1; i < LB_ROWS; i++) begin
            wr_word[i] = old_word[i-1];
        end
        stack[0] = wr_pix;
        for (int d = 1; d < MAX_KERNEL; d++) begin
            stack[d] = old_word[d-1];
        end
        // Kernel row kr takes the pixel kh-1-kr rows back
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            col[kr] = '0;
            for (int d = 0; d < MAX_KERNEL; d++) begin
                if (kr < int'(ker_h) && d == int'(ker_h) - 1 - kr) begin
                    col[kr] = stack[d];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem_reg[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            rd_data_reg  <= line_mem_reg[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_word;
        end
    end

endmodule

// ----- rtl/core/zpc_mac.sv -----
module zpc_mac import zpc_pkg::*; #(
    parameter int MAX_KERNEL     = DEF_MAX_KERNEL,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  zpc_tag_t                          s1_tag,
    input  logic [MAX_KERNEL-1:0][PIX_W-1:0]  col,
    input  logic [MAX_KERNEL-1:0]             s1_rowmask,
    input  logic [MAX_KERNEL-1:0]             s1_colmask,
    input  logic [IDX_W-1:0]                  s1_coef_idx,
    input  logic signed [COEF_W-1:0]          s1_coef_val,
    input  logic [KSIZE_W-1:0]                ker_w,
    output logic                              out_valid,
    output logic [PIX_W-1:0]                  out_pixel,
    output logic                              out_last
);

    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int TOT_W  = ROW_W + $clog2(MAX_KERNEL + 1);

    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] win_reg, win_next;
    logic signed [COEF_W-1:0] coef_reg [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] prod_reg [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] prod_c   [MAX_KERNEL][MAX_KERNEL];
    logic signed [ROW_W-1:0]  rsum_reg [MAX_KERNEL];
    logic signed [ROW_W-1:0]  rsum_c   [MAX_KERNEL];
    logic signed [TOT_W-1:0]  tot_reg, tot_c, shifted;

    zpc_tag_t                 s2_tag_reg;
    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0] s2_mask_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic signed [COEF_W-1:0] s2_val_reg;
    logic s3_valid_reg, s4_valid_reg, s5_valid_reg, out_valid_reg;
    logic s3_last_reg, s4_last_reg, s5_last_reg, out_last_reg;
    logic [PIX_W-1:0] out_pixel_reg, pixel_c;

    // New column enters at kernel column kw-1, older columns move towards 0
    always_comb begin
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            for (int kc = 0; kc < MAX_KERNEL - 1; kc++) begin
                win_next[kr][kc] = win_reg[kr][kc+1];
            end
            win_next[kr][MAX_KERNEL-1] = win_reg[kr][MAX_KERNEL-1];
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                if (kc == int'(ker_w) - 1) begin
                    win_next[kr][kc] = col[kr];
                end
            end
        end
    end

    always_comb begin
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                prod_c[kr][kc] = $signed({1'b0, win_reg[kr][kc]}) * coef_reg[kr][kc];
            end
        end
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            rsum_c[kr] = '0;
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                rsum_c[kr] = rsum_c[kr] + ROW_W'(prod_reg[kr][kc]);
            end
        end
        tot_c = '0;
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            tot_c = tot_c + TOT_W'(rsum_reg[kr]);
        end
        // Truncate the fraction, then clip to the pixel range
        shifted = tot_reg >>> COEF_FRAC_BITS;
        if (tot_reg[TOT_W-1]) begin
            pixel_c = '0;
        end else if (|shifted[TOT_W-1:PIX_W]) begin
            pixel_c = PIX_W'(PIX_MAX);
        end else begin
            pixel_c = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg    <= '0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_tag_reg    <= s1_tag;
            s3_valid_reg  <= s2_tag_reg.emit;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (s1_tag.step) begin
                win_reg <= win_next;
            end
            for (int kr = 0; kr < MAX_KERNEL; kr++) begin
                for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                    s2_mask_reg[kr][kc] <= s1_rowmask[kr] & s1_colmask[kc];
                end
            end
            s2_idx_reg <= s1_coef_idx;
            s2_val_reg <= s1_coef_val;
            // Coefficients change in step with the multiply stage, so earlier
            // items still use the old value
            for (int kr = 0; kr < MAX_KERNEL; kr++) begin
                for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                    if (s2_tag_reg.coef_we && int'(s2_idx_reg) == kr * MAX_KERNEL + kc) begin
                        coef_reg[kr][kc] <= s2_val_reg;
                    end
                    prod_reg[kr][kc] <= s2_mask_reg[kr][kc] ? prod_c[kr][kc]
                                                            : PROD_W'(0);
                end
            end
            s3_last_reg <= s2_tag_reg.last;
            for (int kr = 0; kr < MAX_KERNEL; kr++) begin
                rsum_reg[kr] <= rsum_c[kr];
            end
            s4_last_reg   <= s3_last_reg;
            tot_reg       <= tot_c;
            s5_last_reg   <= s4_last_reg;
            out_pixel_reg <= pixel_c;
            out_last_reg  <= s5_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/core/zpc_checker.sv -----
`include "zero_padded_2d_convolution_macros.svh"

module zpc_checker import zpc_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [PIX_W-1:0] m_tdata,
    input logic             m_tlast
);

    `ZPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ZPC_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `ZPC_ASSERT_SAME(a_ready_free, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input held back with free output")
    `ZPC_ASSERT_SAME(a_ready_stall, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

endmodule

bind zero_padded_2d_convolution zpc_checker u_zpc_checker (.*);

// ----- dv/tb_zero_padded_2d_convolution.sv -----
`timescale 1ns / 100ps

module tb_zero_padded_2d_convolution;
    import zpc_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXK = DEF_MAX_KERNEL;
    localparam int NROWS = MAXK + 1;
    localparam int FRAC = DEF_COEF_FRAC_BITS;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } pix_out_t;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [6:0]       idx;
        logic [15:0]      coef;
        logic [7:0]       pix;
        bit               chk;
        pix_out_t         want;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [PIX_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    zero_padded_2d_convolution DUT (.*);

    // predictor state
    int unsigned img_w, img_h, ker_w, ker_h;
    logic [7:0] rows [NROWS*MAXW];
    logic signed [15:0] kernel [MAXK*MAXK];
    int unsigned row_pos, col_pos;

    pix_out_t pending_pixels [$];
    bit typed_check [$];
    pix_out_t typed_want [$];
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 0;
    longint cycles = 0;

    function automatic int unsigned clampv(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic void set_register(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] d);
        case (a)
            CFG_IMG_W: img_w = d;
            CFG_IMG_H: img_h = d;
            CFG_KER_W: ker_w = d[3:0];
            CFG_KER_H: ker_h = d[3:0];
            default: ;
        endcase
        restart_frame();
    endfunction

    // returns 1 when the item produces a filtered pixel
    function automatic bit filter_step(logic [REQ_W-1:0] kind, logic [6:0] idx,
                                       logic [15:0] coef, logic [7:0] pix,
                                       output pix_out_t res);
        int unsigned w, h, kw, kh, pw, ph, lat, total, t, o, r, c;
        int y, x;
        longint sum;
        longint q;
        w = clampv(img_w, MAXW);
        h = clampv(img_h, DEF_MAX_HEIGHT);
        kw = clampv(ker_w, MAXK);
        kh = clampv(ker_h, MAXK);
        pw = kw / 2;
        ph = kh / 2;
        lat = (kh - 1 - ph) * w + (kw - 1 - pw);
        total = w * h;
        t = row_pos * w + col_pos;
        sum = 0;
        res = '0;
        if (kind == REQ_COEF) begin
            if (idx < MAXK*MAXK) kernel[idx] = coef;
            return 0;
        end
        if (kind != REQ_PIXEL && kind != REQ_FLUSH) return 0;
        if (kind == REQ_FLUSH && t < total) return 0;
        if (t < total) rows[(row_pos % NROWS)*MAXW + col_pos] = pix;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (t < lat) return 0;
        o = t - lat;
        r = o / w;
        c = o % w;
        for (int kr = 0; kr < kh; kr++) begin
            y = int'(r) - int'(ph) + kr;
            if (y < 0 || y >= int'(h)) continue;
            for (int kc = 0; kc < kw; kc++) begin
                x = int'(c) - int'(pw) + kc;
                if (x < 0 || x >= int'(w)) continue;
                sum += longint'(rows[(y % NROWS)*MAXW + x]) * longint'(kernel[kr*MAXK + kc]);
            end
        end
        if (sum < 0) res.pix = 0;
        else begin
            q = sum >>> FRAC;
            res.pix = q > 255 ? 8'd255 : q[7:0];
        end
        res.last = (o + 1 >= total);
        if (res.last) restart_frame();
        return 1;
    endfunction

    // idling control: 0 none, 1 sender, 2 receiver, 3 both
    int idle_mode = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_off) m_tready <= 1'b0;
        else if (idle_mode >= 2) m_tready <= ($urandom_range(99) >= (idle_mode == 2 ? 55 : 30));
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        pix_out_t exp_res;
        bit chk_row;
        pix_out_t want_row;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected output pix=%0d last=%0b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_res = pending_pixels.pop_front();
                chk_row = typed_check.pop_front();
                want_row = typed_want.pop_front();
                if (chk_row && want_row != exp_res) begin
                    $display("%0t: table expects pix=%0d last=%0b, predictor pix=%0d last=%0b",
                             $time, want_row.pix, want_row.last, exp_res.pix, exp_res.last);
                    errors++;
                end
                if (m_tdata !== exp_res.pix || m_tlast !== exp_res.last) begin
                    $display("%0t: expected pix=%0d last=%0b, actual pix=%0d last=%0b",
                             $time, exp_res.pix, exp_res.last, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic [REQ_W-1:0] kind, logic [6:0] idx, logic [15:0] coef,
                             logic [7:0] pix, bit chk = 0, pix_out_t want = '0);
        pix_out_t res;
        while ((idle_mode == 1 || idle_mode == 3) &&
               $urandom_range(99) < (idle_mode == 1 ? 55 : 30)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, pix, coef, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (filter_step(kind, idx, coef, pix, res)) begin
            pending_pixels.push_back(res);
            typed_check.push_back(chk);
            typed_want.push_back(want);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= a;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        set_register(a, d);
    endtask

    task automatic load_kernel(int mode);
        logic [15:0] v;
        for (int i = 0; i < MAXK*MAXK; i++) begin
            case (mode)
                0: v = (i == 4*MAXK + 4 || i == 1*MAXK + 1 || i == 0) ? 16'h1000 : 16'h0000;
                1: v = 16'($urandom_range(16'h0600));
                default: v = 16'($urandom);
            endcase
            send_item(REQ_COEF, i[6:0], v, 8'h00);
        end
    endtask

    // let everything in flight leave the block before touching the registers
    task automatic configure(int w, int h, int kw, int kh);
        drain();
        write_register(CFG_IMG_W, w[CFG_W-1:0]);
        write_register(CFG_IMG_H, h[CFG_W-1:0]);
        write_register(CFG_KER_W, kw[CFG_W-1:0]);
        write_register(CFG_KER_H, kh[CFG_W-1:0]);
    endtask

    // stream one frame with its flush steps, sprinkled with ignored items
    task automatic run_frame(bit noise);
        int unsigned w, h, kw, kh, lat;
        logic [7:0] p;
        w = clampv(img_w, MAXW);
        h = clampv(img_h, DEF_MAX_HEIGHT);
        kw = clampv(ker_w, MAXK);
        kh = clampv(ker_h, MAXK);
        lat = (kh - 1 - kh/2) * w + (kw - 1 - kw/2);
        for (int i = 0; i < w*h; i++) begin
            if (noise && $urandom_range(9) == 0)
                send_item($urandom_range(1) ? REQ_FLUSH : 2'd3, 7'($urandom),
                          16'($urandom), 8'($urandom));
            p = $urandom_range(3) == 0 ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
            send_item(REQ_PIXEL, 7'($urandom), 16'($urandom), p);
        end
        for (int i = 0; i < lat; i++)
            send_item((noise && $urandom_range(3) == 0) ? REQ_PIXEL : REQ_FLUSH,
                      7'($urandom), 16'($urandom), 8'($urandom));
    endtask

    stim_row_t directed [] = '{
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'hFF, 1'b0, '0},
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'hFF, 1'b0, '0},
        '{REQ_FLUSH, 7'd0,   16'h0000, 8'h00, 1'b0, '0},
        '{2'd3,      7'd5,   16'h1234, 8'h55, 1'b0, '0},
        '{REQ_COEF,  7'd127, 16'hFFFF, 8'h00, 1'b0, '0},
        '{REQ_COEF,  7'd81,  16'h8000, 8'h00, 1'b0, '0},
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'hFF, 1'b1, '{8'd255, 1'b0}},
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'h00, 1'b1, '{8'd0, 1'b1}},
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'h80, 1'b0, '0},
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'h01, 1'b1, '{8'd1, 1'b0}},
        '{REQ_PIXEL, 7'd0,   16'h0000, 8'hAA, 1'b0, '0}
    };

    initial begin
        img_w = 1024; img_h = 1024; ker_w = 3; ker_h = 3;
        foreach (rows[i]) rows[i] = '0;
        foreach (kernel[i]) kernel[i] = '0;
        restart_frame();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity kernel centre, 1x1 on 2x2: extremes pass straight through
        load_kernel(0);
        configure(2, 2, 1, 1);
        write_register(CFG_KER_W, 11'h7F1);   // upper bits dropped, still width 1
        // flush mid-frame and bad kinds are ignored
        foreach (directed[i])
            send_item(directed[i].kind, directed[i].idx, directed[i].coef,
                      directed[i].pix, directed[i].chk, directed[i].want);
        drain();
        // negative and saturating kernels, zero-size clamp, oversize kernel clamp
        send_item(REQ_COEF, 7'd0, 16'h8000, 8'h00);
        configure(0, 0, 0, 0);
        run_frame(0);
        drain();
        load_kernel(2);
        configure(3, 2, 15, 15);
        run_frame(0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = ph;
            load_kernel(ph == 2 ? 2 : 1);
            configure($urandom_range(1, 12), $urandom_range(1, 6),
                      $urandom_range(1, 9), $urandom_range(1, 9));
            run_frame(1);
            if (ph == 1) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge aclk);
                        hold_off = 0;
                    end
                    run_frame(0);
                join
            end
            drain();
            configure($urandom_range(2, 20), $urandom_range(2, 8), 9, 9);
            run_frame(1);
            drain();
            configure($urandom_range(4, 30), $urandom_range(1, 4),
                      2 * $urandom_range(0, 4) + 1, 2 * $urandom_range(0, 4) + 1);
            run_frame(0);
            drain();
        end
        idle_mode = 0;
        configure(40, 1, 3, 1);
        run_frame(0);
        drain();
        configure(1, 2, 1, 3);
        run_frame(0);
        drain();

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
